/* sv/bdt_pkg.sv */
// shared types and constants of the block downscale threshold unit
`default_nettype none

package bdt_pkg;

  // fixed field widths
  localparam int unsigned PIXEL_W   = 8;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned FACTOR_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned TDATA_OUT_W = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLOCK_FACTOR = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

/* sv/block_downscale_threshold.sv */
// top level of the block downscale threshold unit: box sum per block and binarize
// a block's closing pixel yields its mask bit through the close stage and then the output register
// throughput: one pixel per cycle unless the output stalls; a block close reads its column sum
//   at accept except in a block's first row, and writes it back next cycle except in its last
// reset: counters clear at once, registers return to width 64, height 64, factor 2;
//   the column sum memory is not cleared, each entry is written before it is read
`default_nettype none

module block_downscale_threshold #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_FACTOR = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bdt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bdt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // pixel input stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [bdt_pkg::PIXEL_W-1:0]   s_axis_tdata_i,  // [7:0] pixel_value
  // mask output stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [bdt_pkg::TDATA_OUT_W-1:0]    m_axis_tdata_o,  // [0] mask_bit, [7:1] zero
  output logic                               m_axis_tlast_o   // last_of_image
);
  import bdt_pkg::*;

  localparam int unsigned IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RSW   = $clog2(MAX_FACTOR * 255 + 1);
  localparam int unsigned SW    = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
  localparam int unsigned MW_W  = $clog2(MAX_WIDTH + 1) + 1;
  localparam int unsigned MF_W  = $clog2(MAX_FACTOR + 1) + 1;
  localparam int unsigned RST_WIDTH = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;

  // effective configuration, stored already clamped
  logic [DIM_W-1:0]    width_q, height_q;
  logic [FACTOR_W-1:0] factor_q;

  // position state
  logic [DIM_W-1:0]    pixel_column_q, pixel_row_q;
  logic [DIM_W-1:0]    col_start_q, row_start_q;
  logic [FACTOR_W-1:0] column_in_block_q, row_in_block_q;
  logic [IDX_W-1:0]    output_column_q;
  logic [RSW-1:0]      row_sum_q;

  // close stage
  logic                s1_valid_q;
  logic                s1_add_mem_q, s1_emit_q, s1_last_q;
  logic [RSW-1:0]      s1_sum_q;
  logic [IDX_W-1:0]    s1_addr_q;
  logic [SW-1:0]       rdata_q;

  // output register
  logic                out_valid_q, out_mask_q, out_last_q;

  // column sum memory
  logic [SW-1:0]       column_sums [MAX_WIDTH];

  logic                s_accept, cfg_accept, s1_adv;
  logic                in_col, in_row, in_region, block_close, row_end, img_end;
  logic                rib_wrap, last_block;
  logic [RSW-1:0]      row_sum_next;
  logic [SW-1:0]       total;
  logic [2*FACTOR_W-1:0] f_sq;
  logic                mask_bit;
  logic [DIM_W:0]      f_ext, f2_ext;
  logic [FACTOR_W-1:0] f_m1;
  logic [DIM_W-1:0]    cfg_w_clamped;
  logic [FACTOR_W-1:0] cfg_f_clamped;

  // handshakes
  assign cfg_ready_o     = 1'b1;
  assign cfg_accept      = cfg_valid_i & cfg_ready_o;
  assign s1_adv          = s1_valid_q & (~s1_emit_q | ~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~s1_valid_q | s1_adv;
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  // region tests: a pixel counts only inside a whole block
  assign f_ext       = (DIM_W + 1)'(factor_q);
  assign f2_ext      = (DIM_W + 1)'({factor_q, 1'b0});
  assign f_m1        = factor_q - FACTOR_W'(1);
  assign in_col      = ({1'b0, col_start_q} + f_ext) <= {1'b0, width_q};
  assign in_row      = ({1'b0, row_start_q} + f_ext) <= {1'b0, height_q};
  assign in_region   = in_col & in_row;
  assign block_close = in_region & (column_in_block_q >= f_m1);
  assign row_end     = pixel_column_q >= (width_q - DIM_W'(1));
  assign img_end     = pixel_row_q >= (height_q - DIM_W'(1));
  assign rib_wrap    = row_in_block_q >= f_m1;
  assign row_sum_next = row_sum_q + RSW'(s_axis_tdata_i);
  // bottom-right block: neither another block row nor another block column fits
  assign last_block  = ({1'b0, row_start_q} + f2_ext > {1'b0, height_q}) &
                       ({1'b0, col_start_q} + f2_ext > {1'b0, width_q});

  // configuration clamping
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_w_clamped = DIM_W'(1);
    end else if (MW_W'(cfg_data_i) > MW_W'(MAX_WIDTH)) begin
      cfg_w_clamped = DIM_W'(MAX_WIDTH);
    end else begin
      cfg_w_clamped = cfg_data_i;
    end
    if (cfg_data_i[FACTOR_W-1:0] == '0) begin
      cfg_f_clamped = FACTOR_W'(1);
    end else if (MF_W'(cfg_data_i[FACTOR_W-1:0]) > MF_W'(MAX_FACTOR)) begin
      cfg_f_clamped = FACTOR_W'(MAX_FACTOR);
    end else begin
      cfg_f_clamped = cfg_data_i[FACTOR_W-1:0];
    end
  end

  // block total and threshold
  assign total    = (s1_add_mem_q ? rdata_q : '0) + SW'(s1_sum_q);
  assign f_sq     = factor_q * factor_q;
  assign mask_bit = {total, 1'b0} > (SW + 1)'(f_sq);

  // configuration and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q           <= DIM_W'(RST_WIDTH);
      height_q          <= DIM_W'(64);
      factor_q          <= FACTOR_W'(2);
      pixel_column_q    <= '0;
      pixel_row_q       <= '0;
      col_start_q       <= '0;
      row_start_q       <= '0;
      column_in_block_q <= '0;
      row_in_block_q    <= '0;
      output_column_q   <= '0;
      row_sum_q         <= '0;
    end else if (cfg_accept) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_w_clamped;
        CFG_IMAGE_HEIGHT: height_q <= (cfg_data_i == '0) ? DIM_W'(1) : cfg_data_i;
        CFG_BLOCK_FACTOR: factor_q <= cfg_f_clamped;
        default: ;
      endcase
      if (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT ||
          cfg_index_i == CFG_BLOCK_FACTOR) begin
        pixel_column_q    <= '0;
        pixel_row_q       <= '0;
        col_start_q       <= '0;
        row_start_q       <= '0;
        column_in_block_q <= '0;
        row_in_block_q    <= '0;
        output_column_q   <= '0;
        row_sum_q         <= '0;
      end
    end else if (s_accept) begin
      if (row_end) begin
        pixel_column_q    <= '0;
        col_start_q       <= '0;
        column_in_block_q <= '0;
        output_column_q   <= '0;
        row_sum_q         <= '0;
        if (img_end) begin
          pixel_row_q    <= '0;
          row_start_q    <= '0;
          row_in_block_q <= '0;
        end else begin
          pixel_row_q <= pixel_row_q + DIM_W'(1);
          if (in_row) begin
            if (rib_wrap) begin
              row_in_block_q <= '0;
              row_start_q    <= pixel_row_q + DIM_W'(1);
            end else begin
              row_in_block_q <= row_in_block_q + FACTOR_W'(1);
            end
          end
        end
      end else begin
        pixel_column_q <= pixel_column_q + DIM_W'(1);
        if (in_region) begin
          if (block_close) begin
            row_sum_q         <= '0;
            column_in_block_q <= '0;
            output_column_q   <= output_column_q + IDX_W'(1);
            col_start_q       <= pixel_column_q + DIM_W'(1);
          end else begin
            row_sum_q         <= row_sum_next;
            column_in_block_q <= column_in_block_q + FACTOR_W'(1);
          end
        end
      end
    end
  end

  // close stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid_q <= block_close;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_emit_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // close stage and output payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_add_mem_q <= row_in_block_q != '0;
      s1_emit_q    <= rib_wrap;
      s1_last_q    <= rib_wrap & last_block;
      s1_sum_q     <= row_sum_next;
      s1_addr_q    <= output_column_q;
    end
    if (s1_adv && s1_emit_q) begin
      out_mask_q <= mask_bit;
      out_last_q <= s1_last_q;
    end
  end

  // column sum memory: read at accept, written back from the close stage;
  // an entry is revisited only a full row later, after its write has landed
  always_ff @(posedge clk_i) begin
    if (s_accept && block_close && row_in_block_q != '0) begin
      rdata_q <= column_sums[output_column_q];
    end
    if (s1_adv && !s1_emit_q) begin
      column_sums[s1_addr_q] <= total;
    end
  end

  // output ports
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDATA_OUT_W'(out_mask_q);
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

/* sv/bdt_checker.sv */
// port-level checker of the block downscale threshold unit and its bind
`default_nettype none

module bdt_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [bdt_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o,
  input wire logic                           m_axis_tlast_o
);
  import bdt_pkg::*;

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output changed");

  // a new result is traced back to an accepted pixel transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a closing pixel");

  // input backpressure only while the output register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // padding bits of the result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[TDATA_OUT_W-1:1] == '0)
    else $error("nonzero padding in result");

endmodule

bind block_downscale_threshold bdt_checker u_bdt_checker (.*);

`default_nettype wire
